// ===== hw/rtl/pts_pkg.sv =====
// pts_pkg: shared types, token kind codes, keyword table and character classes
`default_nettype none

package pts_pkg;

   // default sizes
   localparam int MAX_NAME_DEF   = 31;
   localparam int MAX_DIGITS_DEF = 14;

   // fixed field widths
   localparam int KIND_W       = 6;
   localparam int VALUE_W      = 32;
   localparam int NAME_LEN_W   = 5;
   localparam int NAME_COUNT_W = 6;
   localparam int DIGIT_CNT_W  = 5;
   localparam int CHARS_W      = 256;
   localparam int KW_COUNT     = 13;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd13;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd14;
   localparam logic [KIND_W-1:0] KIND_TIMES   = 6'd15;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd16;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd17;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd18;
   localparam logic [KIND_W-1:0] KIND_EQL     = 6'd19;
   localparam logic [KIND_W-1:0] KIND_LSS     = 6'd20;
   localparam logic [KIND_W-1:0] KIND_GTR     = 6'd21;
   localparam logic [KIND_W-1:0] KIND_NEQ     = 6'd22;
   localparam logic [KIND_W-1:0] KIND_LEQ     = 6'd23;
   localparam logic [KIND_W-1:0] KIND_GEQ     = 6'd24;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd25;
   localparam logic [KIND_W-1:0] KIND_PERIOD  = 6'd26;
   localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd27;
   localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd28;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd29;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd30;
   localparam logic [KIND_W-1:0] KIND_NUL     = 6'd31;
   localparam logic [KIND_W-1:0] KIND_OTHER   = 6'd32;

   // characters of interest
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_LESS  = 8'h3c;
   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CH_GREAT = 8'h3e;

   // keyword text, first character in the low byte, zero padded
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'h0000_006e_6967_6562,   // begin
      64'h0000_0000_0064_6e65,   // end
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_6e65_6874,   // then
      64'h0000_0065_6c69_6877,   // while
      64'h0000_0000_0000_6f64,   // do
      64'h0000_6e72_7574_6572,   // return
      64'h6e6f_6974_636e_7566,   // function
      64'h0000_0000_0072_6176,   // var
      64'h0000_0074_736e_6f63,   // const
      64'h0000_0000_0064_646f,   // odd
      64'h0000_0065_7469_7277,   // write
      64'h006e_6c65_7469_7277    // writeln
   };
   localparam logic [NAME_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      5'd5, 5'd3, 5'd2, 5'd4, 5'd5, 5'd2, 5'd6, 5'd8, 5'd3, 5'd5, 5'd3, 5'd5, 5'd7
   };

   // what is waiting for the next character
   typedef enum logic [2:0] {
      PEND_NONE    = 3'd0,
      PEND_NAME    = 3'd1,
      PEND_NUMBER  = 3'd2,
      PEND_COLON   = 3'd3,
      PEND_LESS    = 3'd4,
      PEND_GREATER = 3'd5
   } pend_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [VALUE_W-1:0]    value;
      logic                  too_large;
      logic [NAME_LEN_W-1:0] name_len;
      logic                  too_long;
      logic [CHARS_W-1:0]    chars;
      logic                  last;
   } token_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF;
   endfunction

   // kind of a one-character token
   function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
      logic [KIND_W-1:0] k;
      case (c)
         8'h2b:   k = KIND_PLUS;
         8'h2d:   k = KIND_MINUS;
         8'h2a:   k = KIND_TIMES;
         8'h2f:   k = KIND_SLASH;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h3d:   k = KIND_EQL;
         8'h2c:   k = KIND_COMMA;
         8'h2e:   k = KIND_PERIOD;
         8'h3b:   k = KIND_SEMI;
         default: k = KIND_OTHER;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pl0_token_scanner_core.sv =====
// pl0_token_scanner_core: PL/0 lexical scanner, one source character per request
`default_nettype none

// Usage
//  - req channel: one source byte per request on req_char_in, taken at a clock
//    edge where req_valid is high and req_stall is low
//  - rsp channel: one token per request on the rsp_ fields, taken at an edge
//    where rsp_valid is high and rsp_stall is low; rsp_last_of_run marks the
//    final token caused by one character
//  - a character may yield no token (blanks, or a name or number still being
//    built), one token, or two (the completed pending token and its own)
//  - a token is written into the registered result queue when the character that completes it is taken
//  - one character per cycle: the scan state and the keyword compare settle
//    in the cycle the request is taken; the only limit is the result port,
//    which drains one token per cycle from a four entry result queue
//  - req_stall is high while the queue holds more than two tokens, so a
//    taken character always finds room for both of the tokens it may yield
//  - when the receiver stalls, the head token holds and the queue fills;
//    requests stop once it can no longer take two tokens
//  - synchronous reset empties the queue and clears the scan state; a name,
//    number or operator prefix still pending is dropped without a token
module pl0_token_scanner_core
   import pts_pkg::*;
#(
   parameter int MAX_NAME   = MAX_NAME_DEF,
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_char_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [KIND_W-1:0]          rsp_token_kind,
   output logic [VALUE_W-1:0]         rsp_number_value,
   output logic                       rsp_number_too_large,
   output logic [NAME_LEN_W-1:0]      rsp_name_length,
   output logic                       rsp_name_too_long,
   output logic [63:0]                rsp_name_chars_a,
   output logic [63:0]                rsp_name_chars_b,
   output logic [63:0]                rsp_name_chars_c,
   output logic [63:0]                rsp_name_chars_d,
   output logic                       rsp_last_of_run
);

   // name buffer keeps the characters that survive truncation
   localparam int NAME_DEPTH = MAX_NAME - 1;
   localparam int IDX_W      = $clog2(NAME_DEPTH);
   localparam int Q_DEPTH    = 4;
   localparam int QP_W       = 2;
   localparam int QC_W       = 3;

   // scan state
   pend_type                pend_ff, pend_in;
   logic [NAME_COUNT_W-1:0] name_count_ff, name_count_in;
   logic [VALUE_W-1:0]      acc_ff, acc_in;
   logic [DIGIT_CNT_W-1:0]  digit_count_ff, digit_count_in;
   logic [7:0]              name_buf_ff [NAME_DEPTH];
   logic                    buf_we;
   logic [IDX_W-1:0]        buf_waddr;

   // result queue
   token_type               queue_ff [Q_DEPTH];
   logic [QP_W-1:0]         head_ff, head_in;
   logic [QP_W-1:0]         tail_ff, tail_in;
   logic [QC_W-1:0]         count_ff, count_in;

   logic                    accept;
   logic                    pop;
   logic                    c_letter, c_digit, c_blank;
   logic                    scan_fresh;
   logic                    flush_valid, fresh_valid;
   token_type               flush_tok, fresh_tok;
   token_type               push0, push1;
   logic [1:0]              n_push;

   // name token pieces
   logic                    name_too_long;
   logic [NAME_LEN_W-1:0]   name_len;
   logic [CHARS_W-1:0]      name_flat;
   logic                    kw_found;
   logic [KIND_W-1:0]       kw_kind;
   token_type               name_tok;
   token_type               number_tok;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > QC_W'(Q_DEPTH - 2);
   assign rsp_valid = count_ff != '0;

   assign c_letter = is_letter(req_char_in);
   assign c_digit  = is_digit(req_char_in);
   assign c_blank  = is_blank(req_char_in);

   // ---------------------------------------------------------------------
   // name token: truncated length, zero padded characters, keyword lookup
   // ---------------------------------------------------------------------
   assign name_too_long = name_count_ff >= NAME_COUNT_W'(MAX_NAME);
   assign name_len      = name_too_long ? NAME_LEN_W'(NAME_DEPTH)
                                        : name_count_ff[NAME_LEN_W-1:0];

   for (genvar gi = 0; gi < CHARS_W / 8; gi++) begin : g_flat
      if (gi < NAME_DEPTH) begin : g_live
         assign name_flat[gi*8 +: 8] = (NAME_LEN_W'(gi) < name_len) ? name_buf_ff[gi]
                                                                   : 8'h00;
      end else begin : g_pad
         assign name_flat[gi*8 +: 8] = 8'h00;
      end
   end

   // bytes past the length are zero, so a padded compare is exact
   always_comb begin
      kw_found = 1'b0;
      kw_kind  = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!kw_found && name_len == KW_LEN[k] && name_flat[63:0] == KW_TEXT[k]) begin
            kw_found = 1'b1;
            kw_kind  = KIND_W'(k);
         end
      end
   end

   always_comb begin
      name_tok          = '0;
      name_tok.too_long = name_too_long;
      if (kw_found) begin
         name_tok.kind = kw_kind;
      end else begin
         name_tok.kind     = KIND_IDENT;
         name_tok.name_len = name_len;
         name_tok.chars    = name_flat;
      end
   end

   always_comb begin
      number_tok           = '0;
      number_tok.kind      = KIND_NUMBER;
      number_tok.value     = acc_ff;
      number_tok.too_large = digit_count_ff > DIGIT_CNT_W'(MAX_DIGITS);
   end

   // ---------------------------------------------------------------------
   // does this character end what is pending and get scanned on its own
   // ---------------------------------------------------------------------
   always_comb begin
      case (pend_ff)
         PEND_NAME:    scan_fresh = !(c_letter || c_digit);
         PEND_NUMBER:  scan_fresh = !c_digit;
         PEND_COLON:   scan_fresh = req_char_in != CH_EQUAL;
         PEND_LESS:    scan_fresh = req_char_in != CH_EQUAL && req_char_in != CH_GREAT;
         PEND_GREATER: scan_fresh = req_char_in != CH_EQUAL;
         default:      scan_fresh = 1'b1;
      endcase
   end

   // ---------------------------------------------------------------------
   // next scan state
   // ---------------------------------------------------------------------
   always_comb begin
      pend_in        = pend_ff;
      name_count_in  = name_count_ff;
      acc_in         = acc_ff;
      digit_count_in = digit_count_ff;
      buf_we         = 1'b0;
      buf_waddr      = name_count_ff[IDX_W-1:0];
      if (scan_fresh) begin
         pend_in = PEND_NONE;
         if (c_letter) begin
            pend_in       = PEND_NAME;
            buf_we        = 1'b1;
            buf_waddr     = '0;
            name_count_in = NAME_COUNT_W'(1);
         end else if (c_digit) begin
            pend_in        = PEND_NUMBER;
            acc_in         = {28'd0, req_char_in[3:0]};
            digit_count_in = DIGIT_CNT_W'(1);
         end else if (req_char_in == CH_COLON) begin
            pend_in = PEND_COLON;
         end else if (req_char_in == CH_LESS) begin
            pend_in = PEND_LESS;
         end else if (req_char_in == CH_GREAT) begin
            pend_in = PEND_GREATER;
         end
      end else begin
         case (pend_ff)
            PEND_NAME: begin
               // characters past the truncation point are counted, not kept
               buf_we = name_count_ff < NAME_COUNT_W'(NAME_DEPTH);
               if (name_count_ff < NAME_COUNT_W'(MAX_NAME)) begin
                  name_count_in = name_count_ff + NAME_COUNT_W'(1);
               end
            end
            PEND_NUMBER: begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + {28'd0, req_char_in[3:0]};
               if (digit_count_ff <= DIGIT_CNT_W'(MAX_DIGITS)) begin
                  digit_count_in = digit_count_ff + DIGIT_CNT_W'(1);
               end
            end
            default: begin
               // two-character operator completed
               pend_in = PEND_NONE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // tokens caused by this character
   // ---------------------------------------------------------------------
   always_comb begin
      flush_valid = 1'b0;
      flush_tok   = '0;
      case (pend_ff)
         PEND_NAME: begin
            flush_valid = scan_fresh;
            flush_tok   = name_tok;
         end
         PEND_NUMBER: begin
            flush_valid = scan_fresh;
            flush_tok   = number_tok;
         end
         PEND_COLON: begin
            flush_valid    = 1'b1;
            flush_tok.kind = scan_fresh ? KIND_NUL : KIND_ASSIGN;
         end
         PEND_LESS: begin
            flush_valid = 1'b1;
            if (scan_fresh) begin
               flush_tok.kind = KIND_LSS;
            end else if (req_char_in == CH_EQUAL) begin
               flush_tok.kind = KIND_LEQ;
            end else begin
               flush_tok.kind = KIND_NEQ;
            end
         end
         PEND_GREATER: begin
            flush_valid    = 1'b1;
            flush_tok.kind = scan_fresh ? KIND_GTR : KIND_GEQ;
         end
         default: begin
            flush_valid = 1'b0;
         end
      endcase

      fresh_tok      = '0;
      fresh_tok.kind = single_kind(req_char_in);
      fresh_tok.last = 1'b1;
      fresh_valid    = scan_fresh && !c_blank && !c_letter && !c_digit
                       && req_char_in != CH_COLON && req_char_in != CH_LESS
                       && req_char_in != CH_GREAT;
      flush_tok.last = !fresh_valid;
   end

   assign push0  = flush_valid ? flush_tok : fresh_tok;
   assign push1  = fresh_tok;
   assign n_push = accept ? ({1'b0, flush_valid} + {1'b0, fresh_valid}) : 2'd0;

   // ---------------------------------------------------------------------
   // queue pointers
   // ---------------------------------------------------------------------
   always_comb begin
      head_in  = pop ? head_ff + QP_W'(1) : head_ff;
      tail_in  = tail_ff + QP_W'(n_push);
      count_in = count_ff + QC_W'(n_push) - QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff        <= PEND_NONE;
         name_count_ff  <= '0;
         acc_ff         <= '0;
         digit_count_ff <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
      end else begin
         if (accept) begin
            pend_ff        <= pend_in;
            name_count_ff  <= name_count_in;
            acc_ff         <= acc_in;
            digit_count_ff <= digit_count_in;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (accept && buf_we) begin
         name_buf_ff[buf_waddr] <= req_char_in;
      end
      if (n_push != 2'd0) begin
         queue_ff[tail_ff] <= push0;
      end
      if (n_push == 2'd2) begin
         queue_ff[tail_ff + QP_W'(1)] <= push1;
      end
   end

   // head of queue to the result ports
   assign rsp_token_kind       = queue_ff[head_ff].kind;
   assign rsp_number_value     = queue_ff[head_ff].value;
   assign rsp_number_too_large = queue_ff[head_ff].too_large;
   assign rsp_name_length      = queue_ff[head_ff].name_len;
   assign rsp_name_too_long    = queue_ff[head_ff].too_long;
   assign rsp_name_chars_a     = queue_ff[head_ff].chars[63:0];
   assign rsp_name_chars_b     = queue_ff[head_ff].chars[127:64];
   assign rsp_name_chars_c     = queue_ff[head_ff].chars[191:128];
   assign rsp_name_chars_d     = queue_ff[head_ff].chars[255:192];
   assign rsp_last_of_run      = queue_ff[head_ff].last;

endmodule

`default_nettype wire

// ===== hw/rtl/pts_checker.sv =====
// pts_checker: port-level assertions for the token scanner, bound to the top level
`default_nettype none

module pts_checker
   import pts_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic [7:0]            req_char_in,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [KIND_W-1:0]     rsp_token_kind,
   input wire logic [VALUE_W-1:0]    rsp_number_value,
   input wire logic                  rsp_number_too_large,
   input wire logic [NAME_LEN_W-1:0] rsp_name_length,
   input wire logic                  rsp_name_too_long,
   input wire logic [63:0]           rsp_name_chars_a,
   input wire logic [63:0]           rsp_name_chars_b,
   input wire logic [63:0]           rsp_name_chars_c,
   input wire logic [63:0]           rsp_name_chars_d,
   input wire logic                  rsp_last_of_run
);

   // a stalled token holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_number_value) && $stable(rsp_name_chars_a)
         && $stable(rsp_last_of_run))
      else $error("stalled token changed");

   // reset leaves no token and takes requests
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

   // only numbers carry a value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_NUMBER |-> rsp_number_value == '0
         && !rsp_number_too_large)
      else $error("value on a token that is no number");

   // only identifiers carry characters
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_IDENT |-> rsp_name_length == '0
         && rsp_name_chars_a == '0 && rsp_name_chars_b == '0
         && rsp_name_chars_c == '0 && rsp_name_chars_d == '0)
      else $error("name characters on a token that is no identifier");

   // an identifier is never empty and its first character is a letter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_IDENT |-> rsp_name_length != '0
         && is_letter(rsp_name_chars_a[7:0]))
      else $error("identifier without a leading letter");

endmodule

bind pl0_token_scanner_core pts_checker u_pts_checker (.*);

`default_nettype wire

// ===== sim/pl0_token_scanner_checker.sv =====
// pl0_token_scanner_checker: predicts tokens from accepted characters and compares them
`timescale 1ns / 100ps

module pl0_token_scanner_checker
   import pts_pkg::*;
#(
   parameter int MAX_NAME   = MAX_NAME_DEF,
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [7:0]            req_char_in,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [KIND_W-1:0]     rsp_token_kind,
   input  wire logic [VALUE_W-1:0]    rsp_number_value,
   input  wire logic                  rsp_number_too_large,
   input  wire logic [NAME_LEN_W-1:0] rsp_name_length,
   input  wire logic                  rsp_name_too_long,
   input  wire logic [63:0]           rsp_name_chars_a,
   input  wire logic [63:0]           rsp_name_chars_b,
   input  wire logic [63:0]           rsp_name_chars_c,
   input  wire logic [63:0]           rsp_name_chars_d,
   input  wire logic                  rsp_last_of_run,
   output int                         token_errors,
   output int                         tokens_outstanding
);

   localparam logic [KIND_W-1:0] KIND_BEGIN    = 6'd0;
   localparam logic [KIND_W-1:0] KIND_END      = 6'd1;
   localparam logic [KIND_W-1:0] KIND_IF       = 6'd2;
   localparam logic [KIND_W-1:0] KIND_THEN     = 6'd3;
   localparam logic [KIND_W-1:0] KIND_WHILE    = 6'd4;
   localparam logic [KIND_W-1:0] KIND_DO       = 6'd5;
   localparam logic [KIND_W-1:0] KIND_RETURN   = 6'd6;
   localparam logic [KIND_W-1:0] KIND_FUNCTION = 6'd7;
   localparam logic [KIND_W-1:0] KIND_VAR      = 6'd8;
   localparam logic [KIND_W-1:0] KIND_CONST    = 6'd9;
   localparam logic [KIND_W-1:0] KIND_ODD      = 6'd10;
   localparam logic [KIND_W-1:0] KIND_WRITE    = 6'd11;
   localparam logic [KIND_W-1:0] KIND_WRITELN  = 6'd12;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [VALUE_W-1:0]    value;
      logic                  too_large;
      logic [NAME_LEN_W-1:0] name_len;
      logic                  too_long;
      logic [255:0]          chars;
      logic                  last;
   } scanned_token_type;

   pend_type           scan_pend;
   logic [7:0]         name_bytes [0:MAX_NAME-1];
   int                 name_cnt;
   logic [VALUE_W-1:0] num_acc;
   int                 digit_cnt;
   scanned_token_type  expected_tokens [$];
   scanned_token_type  head_token;

   initial begin
      token_errors = 0;
      tokens_outstanding = 0;
      for (int i = 0; i < MAX_NAME; i++) name_bytes[i] = 8'h00;
   end

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // word holds the name first character highest, so it lines up with a string literal
   function automatic logic [KIND_W-1:0] keyword_kind(input logic [63:0] word);
      logic [KIND_W-1:0] k;
      case (word)
         "begin":    k = KIND_BEGIN;
         "end":      k = KIND_END;
         "if":       k = KIND_IF;
         "then":     k = KIND_THEN;
         "while":    k = KIND_WHILE;
         "do":       k = KIND_DO;
         "return":   k = KIND_RETURN;
         "function": k = KIND_FUNCTION;
         "var":      k = KIND_VAR;
         "const":    k = KIND_CONST;
         "odd":      k = KIND_ODD;
         "write":    k = KIND_WRITE;
         "writeln":  k = KIND_WRITELN;
         default:    k = KIND_IDENT;
      endcase
      return k;
   endfunction

   function automatic scanned_token_type kind_token(input logic [KIND_W-1:0] k);
      scanned_token_type t;
      t = '0;
      t.kind = k;
      return t;
   endfunction

   function automatic scanned_token_type number_token();
      scanned_token_type t;
      t = '0;
      t.kind = KIND_NUMBER;
      t.value = num_acc;
      t.too_large = digit_cnt > MAX_DIGITS;
      return t;
   endfunction

   // a keyword is looked up only for names of up to eight characters
   function automatic scanned_token_type name_token();
      scanned_token_type t;
      logic [63:0] word;
      int len;
      int i;
      t = '0;
      word = '0;
      t.too_long = name_cnt >= MAX_NAME;
      len = t.too_long ? MAX_NAME - 1 : name_cnt;
      t.kind = KIND_IDENT;
      if (len <= 8) begin
         for (i = 0; i < len; i++) word = {word[55:0], name_bytes[i]};
         t.kind = keyword_kind(word);
      end
      if (t.kind == KIND_IDENT) begin
         t.name_len = NAME_LEN_W'(len);
         for (i = 0; i < len; i++) t.chars[i*8 +: 8] = name_bytes[i];
      end
      return t;
   endfunction

   // advance the scan by one character, queueing up to two tokens
   task automatic scan_char(input logic [7:0] c);
      scanned_token_type made [2];
      int n;
      int i;
      logic absorbed;
      logic paired;
      logic [KIND_W-1:0] k;
      n = 0;
      absorbed = 1'b0;
      paired = 1'b0;
      case (scan_pend)
         PEND_NAME: begin
            if (is_alpha(c) || is_numeral(c)) begin
               if (name_cnt < MAX_NAME - 1) name_bytes[name_cnt] = c;
               if (name_cnt < MAX_NAME) name_cnt++;
               absorbed = 1'b1;
            end else begin
               made[n] = name_token();
               n++;
            end
         end
         PEND_NUMBER: begin
            if (is_numeral(c)) begin
               num_acc = num_acc * 10 + VALUE_W'(c - "0");
               if (digit_cnt <= MAX_DIGITS) digit_cnt++;
               absorbed = 1'b1;
            end else begin
               made[n] = number_token();
               n++;
            end
         end
         PEND_COLON: begin
            paired = c == CH_EQUAL;
            made[n] = kind_token(paired ? KIND_ASSIGN : KIND_NUL);
            n++;
         end
         PEND_LESS: begin
            paired = c == CH_EQUAL || c == CH_GREAT;
            if (c == CH_EQUAL) made[n] = kind_token(KIND_LEQ);
            else if (c == CH_GREAT) made[n] = kind_token(KIND_NEQ);
            else made[n] = kind_token(KIND_LSS);
            n++;
         end
         PEND_GREATER: begin
            paired = c == CH_EQUAL;
            made[n] = kind_token(paired ? KIND_GEQ : KIND_GTR);
            n++;
         end
         default: ;
      endcase
      if (!absorbed) begin
         scan_pend = PEND_NONE;
         if (!paired) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
               // blank: dropped
            end else if (is_alpha(c)) begin
               scan_pend = PEND_NAME;
               name_bytes[0] = c;
               name_cnt = 1;
            end else if (is_numeral(c)) begin
               scan_pend = PEND_NUMBER;
               num_acc = VALUE_W'(c - "0");
               digit_cnt = 1;
            end else if (c == CH_COLON) begin
               scan_pend = PEND_COLON;
            end else if (c == CH_LESS) begin
               scan_pend = PEND_LESS;
            end else if (c == CH_GREAT) begin
               scan_pend = PEND_GREATER;
            end else begin
               case (c)
                  "+":     k = KIND_PLUS;
                  "-":     k = KIND_MINUS;
                  "*":     k = KIND_TIMES;
                  "/":     k = KIND_SLASH;
                  "(":     k = KIND_LPAREN;
                  ")":     k = KIND_RPAREN;
                  "=":     k = KIND_EQL;
                  ",":     k = KIND_COMMA;
                  ".":     k = KIND_PERIOD;
                  ";":     k = KIND_SEMI;
                  default: k = KIND_OTHER;
               endcase
               made[n] = kind_token(k);
               n++;
            end
         end
         if (n > 0) made[n-1].last = 1'b1;
         for (i = 0; i < n; i++) expected_tokens.push_back(made[i]);
      end
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         token_errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_pend = PEND_NONE;
         name_cnt = 0;
         num_acc = '0;
         digit_cnt = 0;
         expected_tokens.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $error("token of kind %0d arrived with none expected", rsp_token_kind);
               token_errors++;
            end else begin
               head_token = expected_tokens.pop_front();
               check_field("token_kind", 64'(head_token.kind), 64'(rsp_token_kind));
               check_field("number_value", 64'(head_token.value), 64'(rsp_number_value));
               check_field("number_too_large", 64'(head_token.too_large),
                           64'(rsp_number_too_large));
               check_field("name_length", 64'(head_token.name_len), 64'(rsp_name_length));
               check_field("name_too_long", 64'(head_token.too_long),
                           64'(rsp_name_too_long));
               check_field("name_chars_a", head_token.chars[63:0], rsp_name_chars_a);
               check_field("name_chars_b", head_token.chars[127:64], rsp_name_chars_b);
               check_field("name_chars_c", head_token.chars[191:128], rsp_name_chars_c);
               check_field("name_chars_d", head_token.chars[255:192], rsp_name_chars_d);
               check_field("last_of_run", 64'(head_token.last), 64'(rsp_last_of_run));
            end
         end
         if (req_valid && !req_stall) scan_char(req_char_in);
      end
      tokens_outstanding <= expected_tokens.size();
   end

endmodule

// ===== sim/pl0_token_scanner_core_test.sv =====
// pl0_token_scanner_core_test: character stimulus and final verdict for the token scanner
`timescale 1ns / 100ps

module pl0_token_scanner_core_test
   import pts_pkg::*;
();

   localparam int HOLD_CYCLES   = 80;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_ITEMS   = 320;
   localparam int PRESSURE_ITEMS = 200;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic [7:0]            req_char_in = 8'h00;
   logic                  rsp_stall   = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [KIND_W-1:0]     rsp_token_kind;
   logic [VALUE_W-1:0]    rsp_number_value;
   logic                  rsp_number_too_large;
   logic [NAME_LEN_W-1:0] rsp_name_length;
   logic                  rsp_name_too_long;
   logic [63:0]           rsp_name_chars_a;
   logic [63:0]           rsp_name_chars_b;
   logic [63:0]           rsp_name_chars_c;
   logic [63:0]           rsp_name_chars_d;
   logic                  rsp_last_of_run;

   int   token_errors;
   int   tokens_outstanding;
   int   gap_pct      = 0;
   int   stall_pct    = 0;
   int   sent_items   = 0;
   int   quiet_cycles = 0;
   int   hold_left    = 0;
   logic hold_request = 1'b0;

   // keyword spellings, right justified like any string literal
   logic [63:0] keyword_words [13] = '{
      "begin", "end", "if", "then", "while", "do", "return",
      "function", "var", "const", "odd", "write", "writeln"
   };
   // operator characters, the pairing ones listed twice to favour pairs
   logic [135:0] op_chars = ":<>=:<>=+-*/(),.;";

   pl0_token_scanner_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_char_in          (req_char_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_token_kind       (rsp_token_kind),
      .rsp_number_value     (rsp_number_value),
      .rsp_number_too_large (rsp_number_too_large),
      .rsp_name_length      (rsp_name_length),
      .rsp_name_too_long    (rsp_name_too_long),
      .rsp_name_chars_a     (rsp_name_chars_a),
      .rsp_name_chars_b     (rsp_name_chars_b),
      .rsp_name_chars_c     (rsp_name_chars_c),
      .rsp_name_chars_d     (rsp_name_chars_d),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   pl0_token_scanner_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_char_in          (req_char_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_token_kind       (rsp_token_kind),
      .rsp_number_value     (rsp_number_value),
      .rsp_number_too_large (rsp_number_too_large),
      .rsp_name_length      (rsp_name_length),
      .rsp_name_too_long    (rsp_name_too_long),
      .rsp_name_chars_a     (rsp_name_chars_a),
      .rsp_name_chars_b     (rsp_name_chars_b),
      .rsp_name_chars_c     (rsp_name_chars_c),
      .rsp_name_chars_d     (rsp_name_chars_d),
      .rsp_last_of_run      (rsp_last_of_run),
      .token_errors         (token_errors),
      .tokens_outstanding   (tokens_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or one long hold-off when asked, so the result queue fills
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(99) < stall_pct;
         end
      end
   end

   // watchdog: ends the run once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one character, idling first at the current gap rate, and wait for the request to go
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   // send a string literal, first character first; zero padding is skipped
   task automatic send_text(input logic [255:0] text);
      int i;
      for (i = 31; i >= 0; i--)
         if (text[i*8 +: 8] != 8'h00) send_char(text[i*8 +: 8]);
   endtask

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      c = 8'("a" + $urandom_range(25));
      if ($urandom_range(1)) c = c - 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   // keyword, now and then with one letter in upper case so it must fall back to a name
   task automatic send_keyword();
      logic [63:0] word;
      int len;
      int pos;
      int flip;
      word = keyword_words[$urandom_range(12)];
      len = 0;
      for (pos = 0; pos < 8; pos++)
         if (word[pos*8 +: 8] != 8'h00) len = pos + 1;
      flip = ($urandom_range(4) == 0) ? int'($urandom_range(len - 1)) : -1;
      for (pos = len - 1; pos >= 0; pos--)
         send_char(word[pos*8 +: 8] - ((pos == flip) ? 8'h20 : 8'h00));
   endtask

   // mostly short names; a few run past the truncation length
   task automatic send_name();
      int len;
      int i;
      len = ($urandom_range(14) == 0) ? int'($urandom_range(40, 28))
                                      : int'($urandom_range(10, 1));
      send_char(rand_letter());
      for (i = 1; i < len; i++)
         send_char(($urandom_range(3) == 0) ? rand_digit() : rand_letter());
   endtask

   // mostly short numbers; a few overflow the digit limit and wrap
   task automatic send_number();
      int len;
      int i;
      len = ($urandom_range(9) == 0) ? int'($urandom_range(25, 13))
                                     : int'($urandom_range(10, 1));
      for (i = 0; i < len; i++) send_char(rand_digit());
   endtask

   task automatic send_operators();
      int count;
      int i;
      count = int'($urandom_range(3, 1));
      for (i = 0; i < count; i++) send_char(op_chars[$urandom_range(16)*8 +: 8]);
   endtask

   task automatic send_blanks();
      int count;
      int i;
      count = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(2, 1));
      for (i = 0; i < count; i++) begin
         case ($urandom_range(2))
            0:       send_char(CH_SPACE);
            1:       send_char(CH_TAB);
            default: send_char(CH_LF);
         endcase
      end
   endtask

   // a well-formed lexeme most of the time, raw bytes for the rest
   task automatic send_random_token();
      case ($urandom_range(19))
         0, 1, 2, 3:      send_keyword();
         4, 5, 6, 7, 8:   send_name();
         9, 10, 11, 12:   send_number();
         13, 14, 15, 16:  send_operators();
         default:         send_char(8'($urandom_range(255)));
      endcase
      send_blanks();
   endtask

   task automatic run_phase(input int gap, input int stall, input int items);
      int target;
      gap_pct   = gap;
      stall_pct = stall;
      target    = sent_items + items;
      while (sent_items < target) send_random_token();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: every paired operator, lone = ; and /, a lone colon, bytes outside the language
      send_text("if x<>9:=0>=<=:b\t=;");
      send_char(8'h00);
      send_char(8'hff);
      send_char(8'h0d);
      send_text("Var/\n");

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(65, 0, PHASE_ITEMS);
      run_phase(0, 65, PHASE_ITEMS);
      run_phase(32, 32, PHASE_ITEMS);

      // long receiver hold-off while characters keep coming at full rate
      hold_request <= 1'b1;
      run_phase(0, 0, PRESSURE_ITEMS);

      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (tokens_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (token_errors == 0 && tokens_outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/pts_pkg.sv
hw/rtl/pl0_token_scanner_core.sv
hw/rtl/pts_checker.sv
sim/pl0_token_scanner_checker.sv
sim/pl0_token_scanner_core_test.sv
